/* sv/nrgp_pkg.sv */
// Package for the NMEA RMC/GGA fix parser: character codes, caps, header and
// sentence codes, and small helpers.
// No dependencies.
package nrgp_pkg;

  localparam int unsigned MaxSentenceLenDefault = 256;

  // ASCII characters of interest
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChDot    = 8'h2E;
  localparam logic [7:0] ChMinus  = 8'h2D;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChNine   = 8'h39;
  localparam logic [7:0] ChA      = 8'h41;
  localparam logic [7:0] ChC      = 8'h43;
  localparam logic [7:0] ChG      = 8'h47;
  localparam logic [7:0] ChM      = 8'h4D;
  localparam logic [7:0] ChN      = 8'h4E;
  localparam logic [7:0] ChP      = 8'h50;
  localparam logic [7:0] ChR      = 8'h52;
  localparam logic [7:0] ChS      = 8'h53;
  localparam logic [7:0] ChW      = 8'h57;

  // header match progress
  localparam logic [3:0] HdrIdle   = 4'd0;
  localparam logic [3:0] HdrDollar = 4'd1;
  localparam logic [3:0] HdrG      = 4'd2;
  localparam logic [3:0] HdrTalker = 4'd3;
  localparam logic [3:0] HdrR      = 4'd4;
  localparam logic [3:0] HdrRM     = 4'd5;
  localparam logic [3:0] HdrG2     = 4'd6;
  localparam logic [3:0] HdrGG     = 4'd7;
  localparam logic [3:0] HdrDone   = 4'd8;

  // sentence type
  localparam logic [1:0] StNone = 2'd0;
  localparam logic [1:0] StRmc  = 2'd1;
  localparam logic [1:0] StGga  = 2'd2;

  localparam logic [4:0] FieldLast = 5'd31;

  localparam logic [29:0] IntCap     = 30'd999999999;
  localparam logic [29:0] SixCap     = 30'd999999;
  localparam logic [27:0] LatMax     = 28'd54000000;
  localparam logic [27:0] LonMax     = 28'd108000000;
  localparam logic [36:0] SpeedMax   = 37'd999999;
  localparam logic [36:0] CourseMax  = 37'd36000;
  localparam logic [29:0] SatsMax    = 30'd99;
  localparam logic [33:0] AltMax     = 34'd1000000;
  localparam logic [33:0] AltMinMag  = 34'd100000;
  localparam logic [18:0] TimeMax    = 19'd86399;
  localparam logic [11:0] YearBase   = 12'd1999;

  // two BCD digits to binary
  function automatic logic [6:0] bcd2(input logic [3:0] hi, input logic [3:0] lo);
    bcd2 = 7'(hi * 7'd10) + 7'(lo);
  endfunction

endpackage

/* sv/nmea_rmc_gga_fix_parser_top.sv */
// Top level of the NMEA RMC/GGA fix parser: byte input stage, sentence and
// field state, fix record and result register. Depends on nrgp_pkg.
// A byte is registered in the input stage and then processed; the record word
//   for a line feed is registered in the result register and shown on m_axis.
// Throughput: one byte per cycle; only a held result word with m_axis_tready
//   low stalls the input, and only when the next byte would emit a word.
// Reset (rst_ni low, asynchronous): idle, no sentence, empty record, no word.
module nmea_rmc_gga_fix_parser_top #(
  parameter int unsigned MAX_SENTENCE_LEN = nrgp_pkg::MaxSentenceLenDefault
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [0] fix_valid, [17:1] utc_seconds, [22:18] day_of_month,
  // [26:23] month_number, [38:27] full_year, [65:39] latitude,
  // [93:66] longitude, [113:94] ground_speed, [129:114] ground_course,
  // [136:130] satellites, [157:137] altitude, [159:158] zero
  output logic [159:0] m_axis_tdata,
  output logic         m_axis_tuser    // [0] sentence_kind (0 RMC, 1 GGA)
);

  localparam int unsigned CisW = $clog2(MAX_SENTENCE_LEN);
  localparam logic [CisW-1:0] CisLast = CisW'(MAX_SENTENCE_LEN - 1);

  // ---------------- input stage ----------------
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       advance, emits;

  // ---------------- parser state ----------------
  logic [3:0]      hdr_q, hdr_d;
  logic [1:0]      stype_q, stype_d;
  logic [4:0]      fnum_q, fnum_d;
  logic [CisW-1:0] cis_q, cis_d;
  // field accumulation: full integer, its last six digits, integer / 100
  // clamped to 255, and up to four fraction digits
  logic [29:0]      iacc_q, iacc_d;
  logic [5:0][3:0]  bcd_q, bcd_d;
  logic [7:0]       hi2_q, hi2_d;
  logic [3:0][3:0]  frc_q, frc_d;
  logic [2:0]       fcnt_q, fcnt_d;
  logic             neg_q, neg_d, infr_q, infr_d, idig_q, idig_d;
  logic [7:0]       first_q, first_d;
  logic             fch_q, fch_d;
  logic             fill_lat_q, fill_lat_d, fill_lon_q, fill_lon_d;

  // ---------------- fix record ----------------
  logic [16:0]        time_q, time_d;
  logic [4:0]         day_q, day_d;
  logic [3:0]         mon_q, mon_d;
  logic [6:0]         yy_q, yy_d;     // two-digit year plus one, 0 if absent
  logic signed [26:0] lat_q, lat_d;
  logic signed [27:0] lon_q, lon_d;
  logic [19:0]        spd_q, spd_d;
  logic [15:0]        crs_q, crs_d;
  logic [6:0]         sats_q, sats_d;
  logic [20:0]        alt_q, alt_d;
  logic [1:0]         stat_q, stat_d; // [0] set, [1] valid

  // ---------------- field values, from the current field ----------------
  logic        big;
  logic [6:0]  v_hh, v_mm, v_ss;
  logic [18:0] t_raw;
  logic [16:0] t_val;
  logic [13:0] frac4;
  logic [27:0] pos_m;
  logic [27:0] lat_val, lon_val;
  logic [36:0] hund;
  logic [19:0] spd_val;
  logic [15:0] crs_val;
  logic [33:0] alt_m;
  logic [20:0] alt_val;
  logic [6:0]  sats_val;
  logic        first_a, first_s, first_w;

  always_comb begin
    big   = iacc_q > nrgp_pkg::SixCap;
    v_hh  = nrgp_pkg::bcd2(bcd_q[5], bcd_q[4]);
    v_mm  = nrgp_pkg::bcd2(bcd_q[3], bcd_q[2]);
    v_ss  = nrgp_pkg::bcd2(bcd_q[1], bcd_q[0]);
    t_raw = 19'(v_hh * 19'd3600) + 19'(v_mm * 19'd60) + 19'(v_ss);
    t_val = (big || t_raw > nrgp_pkg::TimeMax) ? 17'(nrgp_pkg::TimeMax) : t_raw[16:0];
    frac4 = 14'(frc_q[0] * 14'd1000) + 14'(frc_q[1] * 14'd100)
          + 14'(frc_q[2] * 14'd10) + 14'(frc_q[3]);
    // i/100 above 255 saturates either way
    pos_m = 28'(hi2_q * 28'd600000) + 28'(v_ss * 28'd10000) + 28'(frac4);
    lat_val = neg_q ? '0 : (pos_m > nrgp_pkg::LatMax ? nrgp_pkg::LatMax : pos_m);
    lon_val = neg_q ? '0 : (pos_m > nrgp_pkg::LonMax ? nrgp_pkg::LonMax : pos_m);
    hund    = 37'(iacc_q * 37'd100) + 37'(nrgp_pkg::bcd2(frc_q[0], frc_q[1]));
    spd_val = neg_q ? '0 : (hund > nrgp_pkg::SpeedMax ? 20'(nrgp_pkg::SpeedMax) : hund[19:0]);
    crs_val = neg_q ? '0 : (hund > nrgp_pkg::CourseMax ? 16'(nrgp_pkg::CourseMax)
                                                     : hund[15:0]);
    alt_m   = 34'(iacc_q * 34'd10) + 34'(frc_q[0]);
    if (neg_q) begin
      alt_val = 21'(0) - (alt_m > nrgp_pkg::AltMinMag ? 21'(nrgp_pkg::AltMinMag) : alt_m[20:0]);
    end else begin
      alt_val = alt_m > nrgp_pkg::AltMax ? 21'(nrgp_pkg::AltMax) : alt_m[20:0];
    end
    sats_val = neg_q ? '0 : (iacc_q > nrgp_pkg::SatsMax ? 7'(nrgp_pkg::SatsMax) : iacc_q[6:0]);
    first_a  = fch_q && first_q == nrgp_pkg::ChA;
    first_s  = fch_q && first_q == nrgp_pkg::ChS;
    first_w  = fch_q && first_q == nrgp_pkg::ChW;
  end

  // ---------------- field finish: record update ----------------
  logic       fin;        // evaluate the current field this byte
  logic [6:0] dd, mm;

  always_comb begin
    time_d = time_q; day_d = day_q; mon_d = mon_q; yy_d = yy_q;
    lat_d = lat_q; lon_d = lon_q; spd_d = spd_q; crs_d = crs_q;
    sats_d = sats_q; alt_d = alt_q; stat_d = stat_q;
    fill_lat_d = fill_lat_q; fill_lon_d = fill_lon_q;
    dd = big ? 7'd99 : v_hh;
    mm = big ? 7'd99 : v_mm;
    if (fin && stype_q == nrgp_pkg::StRmc) begin
      case (fnum_q)
        5'd1: time_d = t_val;
        5'd2: stat_d = {first_a, 1'b1};
        5'd3: begin lat_d = $signed(lat_val[26:0]); fill_lat_d = 1'b1; end
        5'd4: if (fill_lat_q && first_s) lat_d = -lat_q;
        5'd5: begin lon_d = $signed(lon_val); fill_lon_d = 1'b1; end
        5'd6: if (fill_lon_q && first_w) lon_d = -lon_q;
        5'd7: spd_d = spd_val;
        5'd8: crs_d = crs_val;
        5'd9: if (idig_q) begin
          day_d = dd > 7'd31 ? 5'd31 : dd[4:0];
          mon_d = mm > 7'd12 ? 4'd12 : mm[3:0];
          yy_d  = (big ? 7'd99 : v_ss) + 7'd1;
        end
        default: ;
      endcase
    end else if (fin && stype_q == nrgp_pkg::StGga) begin
      case (fnum_q)
        5'd1: if (time_q == '0) time_d = t_val;
        5'd2: if (lat_q == '0) begin lat_d = $signed(lat_val[26:0]); fill_lat_d = 1'b1; end
        5'd3: if (fill_lat_q && first_s) lat_d = -lat_q;
        5'd4: if (lon_q == '0) begin lon_d = $signed(lon_val); fill_lon_d = 1'b1; end
        5'd5: if (fill_lon_q && first_w) lon_d = -lon_q;
        5'd6: if (!stat_q[0]) stat_d = {!neg_q && iacc_q != '0, 1'b1};
        5'd7: sats_d = sats_val;
        5'd9: alt_d = alt_val;
        default: ;
      endcase
    end
  end

  // ---------------- byte step ----------------
  logic [7:0]  c;
  logic        is_digit;
  logic [3:0]  dig;
  logic [33:0] t_int;
  logic [11:0] hi2_n;
  logic        clr_field, clr_rec, live;

  always_comb begin
    c        = in_byte_q;
    is_digit = c >= nrgp_pkg::ChZero && c <= nrgp_pkg::ChNine;
    dig      = 4'(c - nrgp_pkg::ChZero);
    t_int    = 34'(iacc_q * 34'd10) + 34'(dig);
    hi2_n    = 12'(hi2_q * 12'd10) + 12'(bcd_q[1]);

    hdr_d = hdr_q; stype_d = stype_q; fnum_d = fnum_q; cis_d = cis_q;
    iacc_d = iacc_q; bcd_d = bcd_q; hi2_d = hi2_q; frc_d = frc_q; fcnt_d = fcnt_q;
    neg_d = neg_q; infr_d = infr_q; idig_d = idig_q; first_d = first_q; fch_d = fch_q;
    fin = 1'b0; clr_field = 1'b0; clr_rec = 1'b0; emits = 1'b0;
    live = 1'b0;

    if (c == nrgp_pkg::ChDollar) begin
      hdr_d = nrgp_pkg::HdrDollar; stype_d = nrgp_pkg::StNone; fnum_d = '0;
      cis_d = CisW'(1); clr_field = 1'b1;
    end else if (c == nrgp_pkg::ChLf) begin
      fin   = 1'b1;
      emits = stype_q != nrgp_pkg::StNone;
      hdr_d = nrgp_pkg::HdrIdle; stype_d = nrgp_pkg::StNone; fnum_d = '0;
      cis_d = '0; clr_field = 1'b1;
    end else if (hdr_q != nrgp_pkg::HdrIdle && cis_q < CisLast) begin
      cis_d = cis_q + CisW'(1);
      live  = 1'b1;
    end

    if (live && stype_q == nrgp_pkg::StNone) begin
      case (hdr_q)
        nrgp_pkg::HdrDollar: hdr_d = c == nrgp_pkg::ChG ? nrgp_pkg::HdrG : nrgp_pkg::HdrIdle;
        nrgp_pkg::HdrG: hdr_d = (c == nrgp_pkg::ChP || c == nrgp_pkg::ChN)
                                ? nrgp_pkg::HdrTalker : nrgp_pkg::HdrIdle;
        nrgp_pkg::HdrTalker: hdr_d = c == nrgp_pkg::ChR ? nrgp_pkg::HdrR
                                   : c == nrgp_pkg::ChG ? nrgp_pkg::HdrG2 : nrgp_pkg::HdrIdle;
        nrgp_pkg::HdrR: hdr_d = c == nrgp_pkg::ChM ? nrgp_pkg::HdrRM : nrgp_pkg::HdrIdle;
        nrgp_pkg::HdrRM: begin
          hdr_d = nrgp_pkg::HdrIdle;
          if (c == nrgp_pkg::ChC) begin
            hdr_d = nrgp_pkg::HdrDone; stype_d = nrgp_pkg::StRmc; clr_rec = 1'b1;
          end
        end
        nrgp_pkg::HdrG2: hdr_d = c == nrgp_pkg::ChG ? nrgp_pkg::HdrGG : nrgp_pkg::HdrIdle;
        nrgp_pkg::HdrGG: begin
          hdr_d = nrgp_pkg::HdrIdle;
          if (c == nrgp_pkg::ChA) begin
            hdr_d = nrgp_pkg::HdrDone; stype_d = nrgp_pkg::StGga;
          end
        end
        default: hdr_d = nrgp_pkg::HdrIdle;
      endcase
    end else if (live) begin
      if (c == nrgp_pkg::ChComma) begin
        fin = 1'b1; clr_field = 1'b1;
        if (fnum_q < nrgp_pkg::FieldLast) fnum_d = fnum_q + 5'd1;
      end else if (c == nrgp_pkg::ChStar || c == nrgp_pkg::ChCr) begin
        fin = 1'b1; clr_field = 1'b1; fnum_d = nrgp_pkg::FieldLast;
      end else begin
        if (!fch_q) begin
          first_d = c;
          if (c == nrgp_pkg::ChMinus) neg_d = 1'b1;
        end
        fch_d = 1'b1;
        if (is_digit) begin
          if (infr_q) begin
            if (fcnt_q < 3'd4) begin
              frc_d[fcnt_q[1:0]] = dig;
              fcnt_d = fcnt_q + 3'd1;
            end
          end else begin
            idig_d = 1'b1;
            if (t_int > 34'(nrgp_pkg::IntCap)) begin
              iacc_d = nrgp_pkg::IntCap;
              bcd_d  = {6{4'd9}};
              hi2_d  = 8'd255;
            end else begin
              iacc_d = t_int[29:0];
              bcd_d  = {bcd_q[4:0], dig};
              hi2_d  = hi2_n > 12'd255 ? 8'd255 : hi2_n[7:0];
            end
          end
        end else if (c == nrgp_pkg::ChDot) begin
          infr_d = 1'b1;
        end
      end
    end

    if (clr_field) begin
      iacc_d = '0; bcd_d = '0; hi2_d = '0; frc_d = '0; fcnt_d = '0;
      neg_d = 1'b0; infr_d = 1'b0; idig_d = 1'b0; first_d = '0; fch_d = 1'b0;
    end
  end

  // ---------------- handshake ----------------
  logic word_en;
  assign advance       = in_vld_q && (!(emits) || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;
  assign word_en       = advance && emits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q <= s_axis_tdata;
    end
  end

  // parser state and record
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q <= nrgp_pkg::HdrIdle; stype_q <= nrgp_pkg::StNone; fnum_q <= '0; cis_q <= '0;
      iacc_q <= '0; bcd_q <= '0; hi2_q <= '0; frc_q <= '0; fcnt_q <= '0;
      neg_q <= 1'b0; infr_q <= 1'b0; idig_q <= 1'b0; first_q <= '0; fch_q <= 1'b0;
      fill_lat_q <= 1'b0; fill_lon_q <= 1'b0;
      time_q <= '0; day_q <= '0; mon_q <= '0; yy_q <= '0; lat_q <= '0; lon_q <= '0;
      spd_q <= '0; crs_q <= '0; sats_q <= '0; alt_q <= '0; stat_q <= '0;
    end else if (advance) begin
      hdr_q <= hdr_d; stype_q <= stype_d; fnum_q <= fnum_d; cis_q <= cis_d;
      iacc_q <= iacc_d; bcd_q <= bcd_d; hi2_q <= hi2_d; frc_q <= frc_d; fcnt_q <= fcnt_d;
      neg_q <= neg_d; infr_q <= infr_d; idig_q <= idig_d; first_q <= first_d; fch_q <= fch_d;
      if (in_byte_q == nrgp_pkg::ChDollar) begin
        fill_lat_q <= 1'b0; fill_lon_q <= 1'b0;
      end else begin
        fill_lat_q <= fill_lat_d; fill_lon_q <= fill_lon_d;
      end
      if (clr_rec) begin
        // RMC header: start from an empty record
        time_q <= '0; day_q <= '0; mon_q <= '0; yy_q <= '0; lat_q <= '0; lon_q <= '0;
        spd_q <= '0; crs_q <= '0; sats_q <= '0; alt_q <= '0; stat_q <= '0;
      end else begin
        time_q <= time_d; day_q <= day_d; mon_q <= mon_d; yy_q <= yy_d;
        lat_q <= lat_d; lon_q <= lon_d; spd_q <= spd_d; crs_q <= crs_d;
        sats_q <= sats_d; alt_q <= alt_d; stat_q <= stat_d;
      end
    end
  end

  // ---------------- result register ----------------
  logic [11:0] year_w;
  assign year_w = yy_d != '0 ? nrgp_pkg::YearBase + 12'(yy_d) : 12'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tvalid <= 1'b0;
    end else if (word_en) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_en) begin
      m_axis_tuser <= stype_q == nrgp_pkg::StGga;
      m_axis_tdata <= {2'b00, alt_d, sats_d, crs_d, spd_d, lon_d, lat_d,
                       year_w, mon_d, day_d, time_d, stat_d[1]};
    end
  end

  // ---------------- checks ----------------
  a_done_has_type: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hdr_q == nrgp_pkg::HdrDone) == (stype_q != nrgp_pkg::StNone))
    else $error("header state and sentence type disagree");

  a_word_from_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    word_en |-> (in_byte_q == nrgp_pkg::ChLf))
    else $error("word emitted for a byte other than line feed");

  a_cis_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cis_q <= CisLast)
    else $error("character count beyond sentence length");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |-> !word_en)
    else $error("pending word overwritten");

endmodule
